// ===== hw/rtl/pfpid_pkg.sv =====
// Package for the path-following dual PID controller.
// Holds fixed-point constants, saturation helpers and the sine table generator.
// No dependencies.
package pfpid_pkg;

   localparam int                 DIV_BITS      = 49;
   localparam logic        [33:0] INV_TWO_PI    = 34'd683565276;
   localparam logic        [33:0] RECIP_FIVE    = 34'h0_CCCC_CCCD;
   localparam logic        [15:0] DUTY_OFFSET   = 16'd39256;
   localparam logic signed [48:0] POS_INT_TOP   = 49'sd65536000;
   localparam logic signed [48:0] HEAD_INT_TOP  = 49'sd6553600;
   localparam logic signed [48:0] INT48_BOTTOM  = -49'sd140737488355328;
   localparam longint unsigned    TWO_PI_Q30    = 64'd6746518852;

   localparam logic [2:0] CSR_GAIN_P_POS  = 3'd0;
   localparam logic [2:0] CSR_GAIN_I_POS  = 3'd1;
   localparam logic [2:0] CSR_GAIN_D_POS  = 3'd2;
   localparam logic [2:0] CSR_GAIN_P_HEAD = 3'd3;
   localparam logic [2:0] CSR_GAIN_I_HEAD = 3'd4;
   localparam logic [2:0] CSR_GAIN_D_HEAD = 3'd5;
   localparam logic [2:0] CSR_FF_GAIN     = 3'd6;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [47:0] clamp_int(input logic signed [48:0] v,
                                                    input logic signed [48:0] top);
      logic signed [48:0] r;
      r = v;
      if (r > top) begin
         r = top;
      end
      if (r < INT48_BOTTOM) begin
         r = INT48_BOTTOM;
      end
      return r[47:0];
   endfunction

   // First-quadrant sine of r / 2^bits turns, Q16, from a Q30 Taylor series.
   function automatic longint quad_sine(input longint unsigned r, input int unsigned bits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint          q;
      x    = (r * TWO_PI_Q30) >> bits;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 110;
      sum  = sum - longint'(term);
      if (sum < 0) begin
         sum = 0;
      end
      q = (sum + 8192) >>> 14;
      if (q > 65536) begin
         q = 65536;
      end
      return q;
   endfunction

   function automatic logic signed [17:0] sine_entry(input int unsigned k,
                                                     input int unsigned bits);
      int unsigned quarter;
      int unsigned quad;
      int unsigned rem;
      longint      v;
      quarter = 1 << (bits - 2);
      quad    = k >> (bits - 2);
      rem     = k & (quarter - 1);
      if (quad[0]) begin
         v = quad_sine(longint'(quarter - rem), bits);
      end else begin
         v = quad_sine(longint'(rem), bits);
      end
      if (quad[1]) begin
         v = -v;
      end
      return v[17:0];
   endfunction

endpackage

// ===== hw/rtl/pfpid_if.sv =====
// Handshake channel interfaces for the path-following controller.
// Request, response and register write channels; depends on nothing.
interface pfpid_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] target_x;
   logic signed [31:0] target_y;
   logic signed [31:0] target_heading;
   logic signed [31:0] turn_radius;
   logic               radius_valid;
   logic signed [31:0] pose_x;
   logic signed [31:0] pose_z;
   logic signed [31:0] pose_heading;
   modport source(output valid, target_x, target_y, target_heading, turn_radius,
                  radius_valid, pose_x, pose_z, pose_heading, input ready);
   modport sink(input valid, target_x, target_y, target_heading, turn_radius,
                radius_valid, pose_x, pose_z, pose_heading, output ready);
endinterface

interface pfpid_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] duty_left;
   logic [15:0] duty_right;
   modport source(output valid, duty_left, duty_right, input ready);
   modport sink(input valid, duty_left, duty_right, output ready);
endinterface

interface pfpid_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/path_follow_dual_pid_ff.sv =====
// Top level of the path-following dual PID controller with curvature feedforward.
// Depends on pfpid_pkg, the channel interfaces in pfpid_if and the divider pfpid_div.

// One item is one control tick: a target path point and the measured pose go in, a
// left and right motor duty come out. The block takes one item at a time. The result
// is offered once the quotient is added and both duties are scaled, and the next item
// can be accepted from that same cycle on. The 49 steps of the bit-serial divider that
// forms the feedforward term set the pace. The cross-track error, both integrals and
// the six gain products are worked out meanwhile by one shared 34 by 34 bit
// multiplier under a small sequencer, which then waits for the quotient. A finished
// result sits in an output register, so the next item is accepted while it waits;
// the block stalls only if a second result is ready before the first is taken, and
// then for as long as the receiver holds off. Register writes are always accepted and
// must only be made while no item is in flight.
module path_follow_dual_pid_ff import pfpid_pkg::*; #(
   parameter int SINE_TABLE_BITS = 10
) (
   input logic        clock,
   input logic        reset,
   pfpid_req_if.sink  req,
   pfpid_rsp_if.source rsp,
   pfpid_csr_if.sink  csr
);

   localparam int          TAB_N     = 1 << SINE_TABLE_BITS;
   localparam logic [47:0] IDX_ROUND = 48'd1 << (47 - SINE_TABLE_BITS);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_PHASE = 5'd1;
   localparam logic [4:0] S_IDX   = 5'd2;
   localparam logic [4:0] S_TAB   = 5'd3;
   localparam logic [4:0] S_MX    = 5'd4;
   localparam logic [4:0] S_MY    = 5'd5;
   localparam logic [4:0] S_EP    = 5'd6;
   localparam logic [4:0] S_DIFF  = 5'd7;
   localparam logic [4:0] S_IP    = 5'd8;
   localparam logic [4:0] S_IH    = 5'd9;
   localparam logic [4:0] S_IHA   = 5'd10;
   localparam logic [4:0] S_GHI   = 5'd11;
   localparam logic [4:0] S_GLO   = 5'd12;
   localparam logic [4:0] S_GSUM  = 5'd13;
   localparam logic [4:0] S_GACC  = 5'd14;
   localparam logic [4:0] S_FF    = 5'd15;
   localparam logic [4:0] S_SPLIT = 5'd16;
   localparam logic [4:0] S_MR    = 5'd17;
   localparam logic [4:0] S_ML    = 5'd18;
   localparam logic [4:0] S_LW    = 5'd19;
   localparam logic [4:0] S_OUT   = 5'd20;

   // Constant sine table, one full turn.
   logic signed [17:0] sine_tab [TAB_N];
   for (genvar gk = 0; gk < TAB_N; gk++) begin : g_tab
      assign sine_tab[gk] = sine_entry(gk, SINE_TABLE_BITS);
   end

   // Registers.
   logic [31:0] gain_p_pos_ff, gain_i_pos_ff, gain_d_pos_ff;
   logic [31:0] gain_p_head_ff, gain_i_head_ff, gain_d_head_ff, ff_gain_ff;

   logic [4:0]         state_ff;
   logic [2:0]         term_ff;
   logic signed [31:0] tx_ff, ty_ff, th_ff, px_ff, pz_ff, ph_ff;
   logic               ff_en_ff, ff_neg_ff;
   logic [SINE_TABLE_BITS-1:0] idx_ff;
   logic signed [17:0] sin_ff, cos_ff;
   logic signed [67:0] prod_ff, tmp_ff;
   logic signed [31:0] ep_ff, ea_ff, prev_ep_ff, prev_ea_ff;
   logic signed [35:0] dp_ff, da_ff;
   logic signed [47:0] pos_int_ff, head_int_ff;
   logic [52:0]        r_ff;
   logic signed [57:0] duty_ff;
   logic [16:0]        dr_ff, dl_ff;
   logic [15:0]        right_ff, left_ff;
   logic               rsp_valid_ff;
   logic [15:0]        rsp_left_ff, rsp_right_ff;

   // Shared multiplier operands.
   logic signed [33:0] mul_a, mul_b;

   logic                       req_fire;
   logic signed [32:0]         rad_wide;
   logic [31:0]                rad_mag;
   logic [DIV_BITS-1:0]        div_numer;
   logic [DIV_BITS-1:0]        div_q;
   logic                       div_done;
   logic [SINE_TABLE_BITS-1:0] idx_cos;
   logic [47:0]                phase_sum;
   logic signed [50:0]         xy_sum;
   logic signed [32:0]         ea_wide;
   logic signed [32:0]         dpe, dae;
   logic [32:0]                ep_abs2, ea_abs2;
   logic signed [48:0]         q_step;
   logic signed [48:0]         e_sel;
   logic [31:0]                g_sel;
   logic [47:0]                m_abs;
   logic [80:0]                gsum;

   assign req_fire  = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = 1'b1;

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.duty_left  = rsp_left_ff;
   assign rsp.duty_right = rsp_right_ff;

   // Feedforward numerator is rounded by adding half the divisor up front.
   assign rad_wide  = req.turn_radius[31] ? -33'(req.turn_radius) : 33'(req.turn_radius);
   assign rad_mag   = rad_wide[31:0];
   assign div_numer = {1'b0, ff_gain_ff, 16'd0} + DIV_BITS'(rad_mag >> 1);

   pfpid_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (req_fire),
      .numer    (div_numer),
      .divisor  (rad_mag),
      .quotient (div_q),
      .done     (div_done)
   );

   assign idx_cos   = idx_ff + SINE_TABLE_BITS'(TAB_N / 4);
   assign phase_sum = prod_ff[47:0] + IDX_ROUND;
   assign xy_sum    = $signed(tmp_ff[50:0]) + $signed(prod_ff[50:0]) + 51'sd32768;
   assign ea_wide   = 33'(th_ff) - 33'(ph_ff);
   assign dpe       = 33'(ep_ff) - 33'(prev_ep_ff);
   assign dae       = 33'(ea_ff) - 33'(prev_ea_ff);
   assign ep_abs2   = (ep_ff[31] ? -33'(ep_ff) : 33'(ep_ff)) + 33'd2;
   assign ea_abs2   = (ea_ff[31] ? -33'(ea_ff) : 33'(ea_ff)) + 33'd2;
   assign q_step    = $signed({19'd0, prod_ff[63:34]});

   // Error and gain for the current gain product.
   always_comb begin
      case (term_ff)
         3'd0: begin e_sel = 49'(ep_ff);       g_sel = gain_p_pos_ff;  end
         3'd1: begin e_sel = 49'(pos_int_ff);  g_sel = gain_i_pos_ff;  end
         3'd2: begin e_sel = 49'(dp_ff);       g_sel = gain_d_pos_ff;  end
         3'd3: begin e_sel = 49'(ea_ff);       g_sel = gain_p_head_ff; end
         3'd4: begin e_sel = 49'(head_int_ff); g_sel = gain_i_head_ff; end
         default: begin e_sel = 49'(da_ff);    g_sel = gain_d_head_ff; end
      endcase
   end

   always_comb begin
      logic signed [48:0] e_abs;
      e_abs = e_sel[48] ? -e_sel : e_sel;
      m_abs = e_abs[47:0];
   end

   assign gsum = ({25'd0, tmp_ff[55:0]} << 24) + {25'd0, prod_ff[55:0]} + (81'd1 << 27);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_PHASE: begin mul_a = 34'(ph_ff);            mul_b = INV_TWO_PI;        end
         S_MX:    begin mul_a = 34'(px_ff) - 34'(tx_ff); mul_b = 34'(sin_ff);      end
         S_MY:    begin mul_a = 34'(ty_ff) - 34'(pz_ff); mul_b = 34'(cos_ff);      end
         S_IP:    begin mul_a = {1'b0, ep_abs2};       mul_b = RECIP_FIVE;        end
         S_IH:    begin mul_a = {1'b0, ea_abs2};       mul_b = RECIP_FIVE;        end
         S_GHI:   begin mul_a = {2'd0, g_sel};         mul_b = {10'd0, m_abs[47:24]}; end
         S_GLO:   begin mul_a = {2'd0, g_sel};         mul_b = {10'd0, m_abs[23:0]};  end
         S_MR:    begin mul_a = {16'd0, dr_ff, 1'b0} + 34'd2; mul_b = RECIP_FIVE; end
         S_ML:    begin mul_a = {16'd0, dl_ff, 1'b0} + 34'd2; mul_b = RECIP_FIVE; end
         default: begin mul_a = '0;                    mul_b = '0;                end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // Register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_pos_ff  <= 32'd6710886;
         gain_i_pos_ff  <= 32'd26844;
         gain_d_pos_ff  <= 32'd2684;
         gain_p_head_ff <= 32'd805306368;
         gain_i_head_ff <= 32'd805306;
         gain_d_head_ff <= 32'd80531;
         ff_gain_ff     <= 32'd0;
      end else if (csr.valid && csr.ready) begin
         case (csr.index)
            CSR_GAIN_P_POS:  gain_p_pos_ff  <= csr.data;
            CSR_GAIN_I_POS:  gain_i_pos_ff  <= csr.data;
            CSR_GAIN_D_POS:  gain_d_pos_ff  <= csr.data;
            CSR_GAIN_P_HEAD: gain_p_head_ff <= csr.data;
            CSR_GAIN_I_HEAD: gain_i_head_ff <= csr.data;
            CSR_GAIN_D_HEAD: gain_d_head_ff <= csr.data;
            CSR_FF_GAIN:     ff_gain_ff     <= csr.data;
            default: ;
         endcase
      end
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         term_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         pos_int_ff   <= '0;
         head_int_ff  <= '0;
         prev_ep_ff   <= '0;
         prev_ea_ff   <= '0;
      end else begin
         // In the output state the hand-over below decides the valid flag itself.
         if (rsp_valid_ff && rsp.ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  tx_ff     <= req.target_x;
                  ty_ff     <= req.target_y;
                  th_ff     <= req.target_heading;
                  px_ff     <= req.pose_x;
                  pz_ff     <= req.pose_z;
                  ph_ff     <= req.pose_heading;
                  ff_en_ff  <= req.radius_valid && (req.turn_radius != 32'sd0);
                  ff_neg_ff <= req.turn_radius[31];
                  state_ff  <= S_PHASE;
               end
            end
            S_PHASE: state_ff <= S_IDX;
            S_IDX: begin
               // Angle to table index: phase in Q48 turns, rounded to the entry.
               idx_ff   <= phase_sum[47 -: SINE_TABLE_BITS];
               state_ff <= S_TAB;
            end
            S_TAB: begin
               sin_ff   <= sine_tab[idx_ff];
               cos_ff   <= sine_tab[idx_cos];
               state_ff <= S_MX;
            end
            S_MX: state_ff <= S_MY;
            S_MY: begin
               tmp_ff   <= prod_ff;
               state_ff <= S_EP;
            end
            S_EP: begin
               ep_ff    <= sat32(64'($signed(xy_sum[50:16])));
               ea_ff    <= sat32(64'(ea_wide));
               state_ff <= S_DIFF;
            end
            S_DIFF: begin
               // Derivatives over the 0.2 s tick are the error step times five.
               dp_ff      <= 36'(dpe) + (36'(dpe) <<< 2);
               da_ff      <= 36'(dae) + (36'(dae) <<< 2);
               prev_ep_ff <= ep_ff;
               prev_ea_ff <= ea_ff;
               state_ff   <= S_IP;
            end
            S_IP: state_ff <= S_IH;
            S_IH: begin
               // Integral step is the error over five, rounded to the nearest step.
               pos_int_ff <= clamp_int(49'(pos_int_ff) + (ep_ff[31] ? -q_step : q_step),
                                       POS_INT_TOP);
               state_ff   <= S_IHA;
            end
            S_IHA: begin
               head_int_ff <= clamp_int(49'(head_int_ff) + (ea_ff[31] ? -q_step : q_step),
                                        HEAD_INT_TOP);
               term_ff     <= '0;
               duty_ff     <= '0;
               state_ff    <= S_GHI;
            end
            S_GHI: state_ff <= S_GLO;
            S_GLO: begin
               tmp_ff   <= prod_ff;
               state_ff <= S_GSUM;
            end
            S_GSUM: begin
               r_ff     <= gsum[80:28];
               state_ff <= S_GACC;
            end
            S_GACC: begin
               duty_ff <= e_sel[48] ? duty_ff - $signed({5'd0, r_ff})
                                    : duty_ff + $signed({5'd0, r_ff});
               if (term_ff == 3'd5) begin
                  state_ff <= S_FF;
               end else begin
                  term_ff  <= term_ff + 3'd1;
                  state_ff <= S_GHI;
               end
            end
            S_FF: begin
               if (div_done) begin
                  if (ff_en_ff) begin
                     duty_ff <= ff_neg_ff ? duty_ff - $signed({9'd0, div_q})
                                          : duty_ff + $signed({9'd0, div_q});
                  end
                  state_ff <= S_SPLIT;
               end
            end
            S_SPLIT: begin
               // Split around one half; a side past one takes all of it.
               if (duty_ff > 58'sd32768) begin
                  dr_ff <= 17'd65536;
                  dl_ff <= 17'd0;
               end else if (duty_ff < -58'sd32768) begin
                  dr_ff <= 17'd0;
                  dl_ff <= 17'd65536;
               end else begin
                  dr_ff <= 17'(58'sd32768 + duty_ff);
                  dl_ff <= 17'(58'sd32768 - duty_ff);
               end
               state_ff <= S_MR;
            end
            S_MR: state_ff <= S_ML;
            S_ML: begin
               right_ff <= prod_ff[49:34] + DUTY_OFFSET;
               state_ff <= S_LW;
            end
            S_LW: begin
               left_ff  <= prod_ff[49:34] + DUTY_OFFSET;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_left_ff  <= left_ff;
                  rsp_right_ff <= right_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== hw/rtl/pfpid_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Uses DIV_BITS from pfpid_pkg.
module pfpid_div import pfpid_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DIV_BITS-1:0] numer,
   input  logic [31:0]         divisor,
   output logic [DIV_BITS-1:0] quotient,
   output logic                done
);

   logic [32:0]         rem_ff;
   logic [DIV_BITS-1:0] num_ff;
   logic [31:0]         den_ff;
   logic [5:0]          cnt_ff;
   logic                busy_ff;
   logic                done_ff;
   logic [32:0]         trial;
   logic                fits;

   assign trial    = {rem_ff[31:0], num_ff[DIV_BITS-1]};
   assign fits     = trial >= {1'b0, den_ff};
   assign quotient = num_ff;
   assign done     = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= 6'(DIV_BITS - 1);
         rem_ff  <= '0;
         num_ff  <= numer;
         den_ff  <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? trial - {1'b0, den_ff} : trial;
         num_ff <= {num_ff[DIV_BITS-2:0], fits};
         if (cnt_ff == 6'd0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end else begin
            cnt_ff <= cnt_ff - 6'd1;
         end
      end
   end

endmodule

// ===== verif/pfpid_checker.sv =====
// Checker for the path-following dual PID controller: watches the request,
// response and register write channels, predicts each duty pair and compares.
// Depends on the channel interfaces in pfpid_if and on pfpid_pkg.
`timescale 1ns / 1ps

module pfpid_checker import pfpid_pkg::*; #(
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic  clock,
   input  logic  reset,
   pfpid_req_if  req,
   pfpid_rsp_if  rsp,
   pfpid_csr_if  csr,
   output int    failures,
   output int    pending
);

   localparam int TAB_N = 1 << SINE_TABLE_BITS;

   typedef struct packed {
      logic [15:0] duty_left;
      logic [15:0] duty_right;
   } duty_pair_type;

   duty_pair_type duty_queue[$];
   int            sine_lut[TAB_N];

   logic [31:0] kp_pos, ki_pos, kd_pos, kp_head, ki_head, kd_head, ff_gain;
   longint      pos_acc, head_acc, last_pos_err, last_head_err;

   function automatic int first_quadrant_sine(input longint unsigned r);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      longint          q;
      x    = (r * 64'd6746518852) >> SINE_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int k = 1; k <= 5; k++) begin
         term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) acc = acc - longint'(term);
         else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      q = (acc + 8192) >>> 14;
      if (q > 65536) q = 65536;
      return int'(q);
   endfunction

   function automatic longint sat_word(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint div_nearest(input longint v, input longint d);
      if (v >= 0) return (v + d / 2) / d;
      return -((-v + d / 2) / d);
   endfunction

   function automatic longint scale_by_gain(input logic [31:0] g, input longint e);
      longint unsigned m;
      longint unsigned hi;
      longint unsigned lo;
      longint unsigned r;
      m  = (e < 0) ? longint'(-e) : longint'(e);
      hi = longint'(g) * (m >> 24);
      lo = longint'(g) * (m & 64'hFF_FFFF);
      r  = (hi >> 4) + ((((hi & 64'd15) << 24) + lo + (64'd1 << 27)) >> 28);
      return (e < 0) ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint accumulate(input longint acc, input longint e,
                                         input longint top);
      longint a;
      a = acc + div_nearest(e, 5);
      if (a > top) a = top;
      if (a < -(64'sd1 <<< 47)) a = -(64'sd1 <<< 47);
      return a;
   endfunction

   function automatic int lut_index(input longint a);
      longint unsigned phase;
      phase = longint'(a * 64'sd683565276);
      phase = phase + (64'd1 << (47 - SINE_TABLE_BITS));
      return int'((phase >> (48 - SINE_TABLE_BITS)) & (TAB_N - 1));
   endfunction

   // Advances the controller state by one tick and returns the duty pair.
   function automatic duty_pair_type control_tick();
      longint tx, ty, th, rad, px, pz, ph;
      longint ff, s, c, ep, ea, dp, da, duty, dr, dl;
      int     idx;
      duty_pair_type p;
      tx  = longint'(req.target_x);
      ty  = longint'(req.target_y);
      th  = longint'(req.target_heading);
      rad = longint'(req.turn_radius);
      px  = longint'(req.pose_x);
      pz  = longint'(req.pose_z);
      ph  = longint'(req.pose_heading);
      ff  = 0;
      if (req.radius_valid && rad != 0) begin
         ff = div_nearest((longint'(ff_gain) <<< 16) * ((rad < 0) ? -1 : 1),
                          (rad < 0) ? -rad : rad);
      end
      idx = lut_index(ph);
      s   = sine_lut[idx];
      c   = sine_lut[(idx + TAB_N / 4) % TAB_N];
      ep  = sat_word((-(tx - px) * s + (ty - pz) * c + 64'sd32768) >>> 16);
      pos_acc = accumulate(pos_acc, ep, 64'sd1000 <<< 16);
      dp  = (ep - last_pos_err) * 5;
      last_pos_err = ep;
      ea  = sat_word(th - ph);
      head_acc = accumulate(head_acc, ea, 64'sd100 <<< 16);
      da  = (ea - last_head_err) * 5;
      last_head_err = ea;
      duty = ff + scale_by_gain(kp_pos, ep) + scale_by_gain(ki_pos, pos_acc)
           + scale_by_gain(kd_pos, dp) + scale_by_gain(kp_head, ea)
           + scale_by_gain(ki_head, head_acc) + scale_by_gain(kd_head, da);
      // Past one on either side the duties saturate to full and zero.
      if (duty > 32768) begin
         dr = 65536; dl = 0;
      end else if (duty < -32768) begin
         dr = 0; dl = 65536;
      end else begin
         dr = 32768 + duty; dl = 32768 - duty;
      end
      dr = (dr * 2 + 2) / 5 + longint'(DUTY_OFFSET);
      dl = (dl * 2 + 2) / 5 + longint'(DUTY_OFFSET);
      p.duty_left  = dl[15:0];
      p.duty_right = dr[15:0];
      return p;
   endfunction

   initial begin
      for (int k = 0; k < TAB_N; k++) begin
         int quarter;
         int q;
         int r;
         int v;
         quarter = TAB_N / 4;
         q = k / quarter;
         r = k % quarter;
         v = (q % 2 == 1) ? first_quadrant_sine(quarter - r) : first_quadrant_sine(r);
         sine_lut[k] = (q >= 2) ? -v : v;
      end
      failures = 0;
      pending  = 0;
   end

   always @(posedge clock) begin
      duty_pair_type want;
      if (reset) begin
         kp_pos  = 32'd6710886;   ki_pos  = 32'd26844;  kd_pos  = 32'd2684;
         kp_head = 32'd805306368; ki_head = 32'd805306; kd_head = 32'd80531;
         ff_gain = 32'd0;
         pos_acc = 0; head_acc = 0; last_pos_err = 0; last_head_err = 0;
         duty_queue.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (duty_queue.size() == 0) begin
               $error("unexpected duty item: left %0d right %0d",
                      rsp.duty_left, rsp.duty_right);
               failures = failures + 1;
            end else begin
               want = duty_queue.pop_front();
               if (rsp.duty_left !== want.duty_left) begin
                  $error("duty_left: expected %0d, actual %0d",
                         want.duty_left, rsp.duty_left);
                  failures = failures + 1;
               end
               if (rsp.duty_right !== want.duty_right) begin
                  $error("duty_right: expected %0d, actual %0d",
                         want.duty_right, rsp.duty_right);
                  failures = failures + 1;
               end
            end
         end
         if (req.valid && req.ready) duty_queue.push_back(control_tick());
         if (csr.valid && csr.ready) begin
            case (csr.index)
               CSR_GAIN_P_POS:  kp_pos  = csr.data;
               CSR_GAIN_I_POS:  ki_pos  = csr.data;
               CSR_GAIN_D_POS:  kd_pos  = csr.data;
               CSR_GAIN_P_HEAD: kp_head = csr.data;
               CSR_GAIN_I_HEAD: ki_head = csr.data;
               CSR_GAIN_D_HEAD: kd_head = csr.data;
               CSR_FF_GAIN:     ff_gain = csr.data;
               default: ;
            endcase
         end
      end
      pending = duty_queue.size();
   end

endmodule

// ===== verif/tb_path_follow_dual_pid_ff.sv =====
// Top of the testbench for the path-following dual PID controller: clock,
// reset, stimulus on the request and register channels, and the verdict.
// Depends on pfpid_pkg, pfpid_if, the block itself and pfpid_checker.
`timescale 1ns / 1ps

module tb_path_follow_dual_pid_ff import pfpid_pkg::*;;

   localparam int CYCLE_LIMIT = 1500000;

   logic clock;
   logic reset;
   int   failures;
   int   pending;
   int   cycle_count;

   // Percent chance per cycle that the sender idles and that the receiver stalls.
   int   send_idle_pct;
   int   recv_stall_pct;

   // The stimulus bumps this counter to ask the receiver for a long hold-off.
   int   hold_requests;

   pfpid_req_if req_bus();
   pfpid_rsp_if rsp_bus();
   pfpid_csr_if csr_bus();

   path_follow_dual_pid_ff DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   pfpid_checker duty_checker (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .rsp      (rsp_bus),
      .csr      (csr_bus),
      .failures (failures),
      .pending  (pending)
   );

   typedef struct {
      logic signed [31:0] tx, ty, th, rad;
      logic               rvalid;
      logic signed [31:0] px, pz, ph;
   } tick_type;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Every input starts at a known value; reset is held from the start and released at a falling edge.
   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.target_x = '0; req_bus.target_y = '0; req_bus.target_heading = '0;
      req_bus.turn_radius = '0; req_bus.radius_valid = 1'b0;
      req_bus.pose_x = '0; req_bus.pose_z = '0; req_bus.pose_heading = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0; csr_bus.index = '0; csr_bus.data = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_requests = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_path_follow_dual_pid_ff: FAIL");
         $finish;
      end
   end
   initial cycle_count = 0;

   // Receiver: random stalls, plus a long hold-off counted here when requested.
   initial begin
      int hold_left;
      int seen_requests;
      hold_left = 0;
      seen_requests = 0;
      forever begin
         @(negedge clock);
         if (hold_requests != seen_requests) begin
            seen_requests = hold_requests;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_bus.ready = 1'b0;
         end else begin
            rsp_bus.ready = ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Drives one item at the falling edge and holds it until it is taken. Ready is
   // looked at a nanosecond after the falling edge, well before the rising one.
   task automatic send_tick(input tick_type t);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.target_x = t.tx; req_bus.target_y = t.ty;
      req_bus.target_heading = t.th; req_bus.turn_radius = t.rad;
      req_bus.radius_valid = t.rvalid;
      req_bus.pose_x = t.px; req_bus.pose_z = t.pz; req_bus.pose_heading = t.ph;
      taken = 1'b0;
      while (!taken) begin
         #1;
         taken = req_bus.ready;
         @(negedge clock);
      end
      req_bus.valid = 1'b0;
   endtask

   task automatic write_register(input logic [2:0] index, input logic [31:0] data);
      logic taken;
      csr_bus.valid = 1'b1;
      csr_bus.index = index;
      csr_bus.data = data;
      taken = 1'b0;
      while (!taken) begin
         #1;
         taken = csr_bus.ready;
         @(negedge clock);
      end
      csr_bus.valid = 1'b0;
   endtask

   // Waits until every expected duty item has come and the block has settled.
   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_all_gains(input logic [31:0] g[7]);
      drain();
      write_register(CSR_GAIN_P_POS, g[0]);
      write_register(CSR_GAIN_I_POS, g[1]);
      write_register(CSR_GAIN_D_POS, g[2]);
      write_register(CSR_GAIN_P_HEAD, g[3]);
      write_register(CSR_GAIN_I_HEAD, g[4]);
      write_register(CSR_GAIN_D_HEAD, g[5]);
      write_register(CSR_FF_GAIN, g[6]);
   endtask

   function automatic logic signed [31:0] rand_word();
      return $urandom();
   endfunction

   // Mostly a pose that tracks the target closely, with headings within a few
   // radians, so the loops stay in their working range; a share of raw noise.
   function automatic tick_type random_tick();
      tick_type t;
      int       radius_kind;
      if ($urandom_range(99) < 75) begin
         t.px = $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
         t.pz = $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
         t.tx = t.px + $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
         t.ty = t.pz + $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
         t.ph = $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
         t.th = t.ph + $signed($urandom_range(32'h0002_0000)) - 32'sh0001_0000;
      end else begin
         t.tx = rand_word(); t.ty = rand_word(); t.th = rand_word();
         t.px = rand_word(); t.pz = rand_word(); t.ph = rand_word();
      end
      radius_kind = $urandom_range(3);
      case (radius_kind)
         0: t.rad = '0;
         1: t.rad = $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
         2: t.rad = $signed($urandom_range(32'h0000_0400)) - 32'sh0000_0200;
         default: t.rad = rand_word();
      endcase
      t.rvalid = ($urandom_range(99) < 70);
      return t;
   endfunction

   function automatic tick_type make_tick(input logic signed [31:0] tx, ty, th, rad,
                                          input logic rv,
                                          input logic signed [31:0] px, pz, ph);
      tick_type t;
      t.tx = tx; t.ty = ty; t.th = th; t.rad = rad; t.rvalid = rv;
      t.px = px; t.pz = pz; t.ph = ph;
      return t;
   endfunction

   initial begin
      logic [31:0] gains[7];
      localparam logic signed [31:0] WMAX = 32'sh7FFF_FFFF;
      localparam logic signed [31:0] WMIN = 32'sh8000_0000;
      @(negedge clock);
      while (reset) @(negedge clock);

      // Directed part with the reset gains, then with a live feedforward term.
      send_tick(make_tick('0, '0, '0, '0, 1'b0, '0, '0, '0));
      send_tick(make_tick(WMAX, WMAX, WMAX, WMAX, 1'b1, WMAX, WMAX, WMAX));
      send_tick(make_tick(WMIN, WMIN, WMIN, WMIN, 1'b1, WMIN, WMIN, WMIN));
      // Errors out of range: the differences overflow and must saturate.
      send_tick(make_tick(WMAX, WMIN, WMAX, 32'sd65536, 1'b1, WMIN, WMAX, WMIN));
      send_tick(make_tick(WMIN, WMAX, WMIN, -32'sd65536, 1'b1, WMAX, WMIN, WMAX));
      // Strong positive and negative heading error: each duty above one in turn.
      send_tick(make_tick('0, '0, 32'sh0010_0000, '0, 1'b1, '0, '0, '0));
      send_tick(make_tick('0, '0, -32'sh0010_0000, '0, 1'b1, '0, '0, '0));
      send_tick(make_tick(32'sh0001_0000, 32'sh0002_0000, 32'sh0000_8000, '0, 1'b1,
                          '0, '0, 32'sh0001_0000));
      // Sustained error drives both integrals into their upper clamp.
      repeat (4) send_tick(make_tick(WMAX, WMAX, WMAX, '0, 1'b0, WMIN, WMIN, '0));
      // Sustained negative error walks the integrals down.
      repeat (4) send_tick(make_tick(WMIN, WMIN, WMIN, '0, 1'b0, WMAX, WMAX, '0));

      gains[0] = 32'd6710886;   gains[1] = 32'd26844;  gains[2] = 32'd2684;
      gains[3] = 32'd805306368; gains[4] = 32'd805306; gains[5] = 32'd80531;
      gains[6] = 32'd655360;
      write_all_gains(gains);
      // Zero radius, invalid radius, and radii of both signs and extremes.
      send_tick(make_tick('0, '0, '0, '0, 1'b1, '0, '0, '0));
      send_tick(make_tick('0, '0, '0, 32'sd65536, 1'b0, '0, '0, '0));
      send_tick(make_tick('0, '0, '0, 32'sd1, 1'b1, '0, '0, '0));
      send_tick(make_tick('0, '0, '0, -32'sd1, 1'b1, '0, '0, '0));
      send_tick(make_tick('0, '0, '0, WMAX, 1'b1, '0, '0, '0));
      send_tick(make_tick('0, '0, '0, WMIN, 1'b1, '0, '0, '0));
      send_tick(make_tick('0, '0, '0, 32'sd3000000, 1'b1, '0, '0, '0));

      // Register writes past the last index are ignored.
      drain();
      write_register(3'd7, 32'hFFFF_FFFF);

      // Random part: four traffic phases, each under its own register setting.
      for (int ph_i = 0; ph_i < 4; ph_i++) begin
         case (ph_i)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
         endcase
         case (ph_i)
            0: for (int g = 0; g < 7; g++) gains[g] = '0;
            1: for (int g = 0; g < 7; g++) gains[g] = 32'hFFFF_FFFF;
            2: begin
               gains[0] = 32'd6710886;   gains[1] = 32'd26844;  gains[2] = 32'd2684;
               gains[3] = 32'd805306368; gains[4] = 32'd805306; gains[5] = 32'd80531;
               gains[6] = $urandom_range(32'h0100_0000);
            end
            default: for (int g = 0; g < 7; g++) gains[g] = $urandom();
         endcase
         write_all_gains(gains);
         for (int n = 0; n < 145; n++) begin
            // Partway through the first phase the receiver holds off while items
            // keep coming, so the block fills and stalls its input.
            if (ph_i == 0 && n == 40) hold_requests = hold_requests + 1;
            // Later the sender pauses until every expected result is back.
            if (ph_i == 3 && n == 70) while (pending != 0) @(negedge clock);
            send_tick(random_tick());
         end
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain();
      if (failures == 0) begin
         $display("tb_path_follow_dual_pid_ff: PASS");
      end else begin
         $display("tb_path_follow_dual_pid_ff: FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/pfpid_pkg.sv
hw/rtl/pfpid_if.sv
hw/rtl/pfpid_div.sv
hw/rtl/path_follow_dual_pid_ff.sv
verif/pfpid_checker.sv
verif/tb_path_follow_dual_pid_ff.sv
